@@ design/xcfr_pkg.sv @@
// Shared constants for the command frame receiver: field widths, item mode
// codes, result kinds and register indexes. No dependencies.
package xcfr_pkg;

  localparam int MODE_W      = 2;
  localparam int BYTE_W      = 8;
  localparam int CIDX_W      = 3;
  localparam int TICK_W      = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int STORE_DEPTH = 256;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  localparam logic [MODE_W-1:0] MODE_BYTE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'd1;

  localparam logic [BYTE_W-1:0] START_MARKER_RST  = 8'd170;
  localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = 16'd100;

endpackage

@@ design/xcfr_if.sv @@
// Valid/ready channel interfaces for the receiver's input and result items.
// Depends on xcfr_pkg.
interface xcfr_in_if;
  import xcfr_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [BYTE_W-1:0] rx_byte;
  logic [BYTE_W-1:0] read_index;
  modport source (output valid, mode, rx_byte, read_index, input ready);
  modport sink   (input valid, mode, rx_byte, read_index, output ready);
endinterface

interface xcfr_out_if;
  import xcfr_pkg::*;
  logic              valid;
  logic              ready;
  logic              result_kind;
  logic [BYTE_W-1:0] command_id;
  logic [BYTE_W-1:0] payload_length;
  logic [CIDX_W-1:0] command_index;
  logic [BYTE_W-1:0] read_byte;
  modport source (output valid, result_kind, command_id, payload_length,
                  command_index, read_byte, input ready);
  modport sink   (input valid, result_kind, command_id, payload_length,
                  command_index, read_byte, output ready);
endinterface

@@ design/xcfr_ram.sv @@
// Payload byte store: one write port, one read port, registered read data.
// Depends on xcfr_pkg.
module xcfr_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [xcfr_pkg::STORE_AW-1:0] waddr,
  input  logic [xcfr_pkg::BYTE_W-1:0]   wdata,
  input  logic                          re,
  input  logic [xcfr_pkg::STORE_AW-1:0] raddr,
  output logic [xcfr_pkg::BYTE_W-1:0]   rdata
);
  import xcfr_pkg::*;

  logic [BYTE_W-1:0] mem [STORE_DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/xor_checked_command_frame_receiver.sv @@
// Serial command frame receiver with XOR-checked header and payload.
// Depends on xcfr_pkg, xcfr_if and xcfr_ram.
//
// Takes one item (byte, tick or store read) every cycle while input ready is
// high. Frame state is updated at the edge that accepts the byte; payload bytes
// go straight into a 256-entry synchronous store. A result passes through two
// registers, the store read stage and the output register. Back-pressure on the
// result channel holds those two registers, and input ready drops only when both
// are full and the output is stalled.
module xor_checked_command_frame_receiver #(
  parameter int COMMAND_COUNT = 5
) (
  input  logic                            clk,
  input  logic                            rst_n,
  xcfr_in_if.sink                         in_ch,
  xcfr_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [xcfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [xcfr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import xcfr_pkg::*;

  localparam logic [1:0] PH_WAIT    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [BYTE_W-1:0] CMD_CNT = BYTE_W'(COMMAND_COUNT);

  logic [BYTE_W-1:0] start_r;
  logic [TICK_W-1:0] timeout_r;

  logic [1:0]        phase_r, phase_nxt;
  logic [BYTE_W-1:0] xor_r, xor_nxt;
  logic [BYTE_W-1:0] pos_r, pos_nxt;
  logic [BYTE_W-1:0] cmd_r, cmd_nxt;
  logic [BYTE_W-1:0] len_r, len_nxt;
  logic [TICK_W-1:0] idle_r, idle_nxt;

  logic in_acc, emit, rd_req, mem_we, in_frame, timed_out;

  logic              s1_valid_r, s1_kind_r, s1_adv;
  logic [BYTE_W-1:0] s1_cmd_r, s1_len_r;
  logic [CIDX_W-1:0] s1_cidx_r, cidx;
  logic [BYTE_W-1:0] rd_data;

  logic              out_valid_r, out_kind_r;
  logic [BYTE_W-1:0] out_cmd_r, out_len_r, out_byte_r;
  logic [CIDX_W-1:0] out_cidx_r;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_frame    = (phase_r == PH_HEADER) || (phase_r == PH_PAYLOAD);
  assign timed_out   = idle_r > timeout_r;
  assign rd_req      = in_acc && (in_ch.mode == MODE_READ);
  assign cidx        = (cmd_r < CMD_CNT) ? cmd_r[CIDX_W-1:0] : CMD_CNT[CIDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= START_MARKER_RST;
      timeout_r <= TIMEOUT_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_MARKER:  start_r   <= cfg_data[BYTE_W-1:0];
        CFG_TIMEOUT_TICKS: timeout_r <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    xor_nxt   = xor_r;
    pos_nxt   = pos_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    idle_nxt  = idle_r;
    emit      = 1'b0;
    mem_we    = 1'b0;
    if (in_acc) begin
      case (in_ch.mode)
        MODE_BYTE: begin
          if (!in_frame) begin
            if (in_ch.rx_byte == start_r) begin
              phase_nxt = PH_HEADER;
              xor_nxt   = in_ch.rx_byte;
              pos_nxt   = '0;
              idle_nxt  = '0;
            end
          end else if (timed_out) begin
            phase_nxt = PH_WAIT;
          end else begin
            idle_nxt = '0;
            if (phase_r == PH_HEADER) begin
              pos_nxt = pos_r + 1'b1;
              if (pos_r == 8'd0) begin
                cmd_nxt = in_ch.rx_byte;
                xor_nxt = xor_r ^ in_ch.rx_byte;
              end else if (pos_r == 8'd1) begin
                len_nxt = in_ch.rx_byte;
                xor_nxt = xor_r ^ in_ch.rx_byte;
              end else if (xor_r != in_ch.rx_byte) begin
                phase_nxt = PH_WAIT;
              end else if (len_r == 8'd0) begin
                emit      = 1'b1;
                phase_nxt = PH_WAIT;
              end else begin
                phase_nxt = PH_PAYLOAD;
                xor_nxt   = '0;
                pos_nxt   = '0;
              end
            end else if (pos_r != len_r) begin
              mem_we  = 1'b1;
              pos_nxt = pos_r + 1'b1;
              xor_nxt = xor_r ^ in_ch.rx_byte;
            end else begin
              phase_nxt = PH_WAIT;
              emit      = (xor_r == in_ch.rx_byte);
            end
          end
        end
        MODE_TICK: begin
          if (idle_r != '1) begin
            idle_nxt = idle_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      xor_r   <= '0;
      pos_r   <= '0;
      cmd_r   <= '0;
      len_r   <= '0;
      idle_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      xor_r   <= xor_nxt;
      pos_r   <= pos_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      idle_r  <= idle_nxt;
    end
  end

  xcfr_ram u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (pos_r[STORE_AW-1:0]),
    .wdata (in_ch.rx_byte),
    .re    (rd_req),
    .raddr (in_ch.read_index[STORE_AW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= emit || rd_req;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r <= rd_req ? KIND_READ : KIND_FRAME;
      s1_cmd_r  <= rd_req ? '0 : cmd_r;
      s1_len_r  <= rd_req ? '0 : len_r;
      s1_cidx_r <= rd_req ? '0 : cidx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_kind_r <= s1_kind_r;
      out_cmd_r  <= s1_cmd_r;
      out_len_r  <= s1_len_r;
      out_cidx_r <= s1_cidx_r;
      out_byte_r <= (s1_kind_r == KIND_READ) ? rd_data : '0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_kind    = out_kind_r;
  assign out_ch.command_id     = out_cmd_r;
  assign out_ch.payload_length = out_len_r;
  assign out_ch.command_index  = out_cidx_r;
  assign out_ch.read_byte      = out_byte_r;

`ifndef SYNTHESIS
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r)
    else $error("pending result lost from read stage");
  a_emit_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> in_frame && !timed_out)
    else $error("frame report outside a frame");
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.mode == MODE_BYTE && in_frame && !timed_out |=> idle_r == '0)
    else $error("idle count not cleared by in-frame byte");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r && out_valid_r && !out_ch.ready)
    else $error("input stalled without a full pipeline");
  a_store_wr: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> phase_r == PH_PAYLOAD && pos_r != len_r)
    else $error("store written outside payload");
`endif

endmodule

@@ bench/xcfr_frame_checker.sv @@
// Result checker for the command frame receiver: follows input items and
// register writes, predicts each result and compares it with the block's output.
// Depends on xcfr_pkg and the channel interfaces in xcfr_if.
`timescale 1ns / 100ps

module xcfr_frame_checker #(
  parameter int COMMAND_COUNT = 5
) (
  input  logic                            clk,
  input  logic                            rst_n,
  xcfr_in_if                              in_mon,
  xcfr_out_if                             out_mon,
  input  logic                            cfg_we,
  input  logic [xcfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [xcfr_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              frames_seen,
  output int                              reads_seen
);
  import xcfr_pkg::*;

  typedef enum logic [1:0] {RX_IDLE, RX_HEADER, RX_PAYLOAD} rx_phase_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] len;
    logic [CIDX_W-1:0] cidx;
    logic [BYTE_W-1:0] rdata;
  } rx_result_t;

  logic [BYTE_W-1:0] marker;
  logic [TICK_W-1:0] timeout;
  rx_phase_t         rx_phase;
  logic [BYTE_W-1:0] frame_xor;
  logic [BYTE_W-1:0] frame_pos;
  logic [BYTE_W-1:0] held_cmd;
  logic [BYTE_W-1:0] held_len;
  logic [TICK_W-1:0] idle_ticks;
  logic [BYTE_W-1:0] payload_mem [0:STORE_DEPTH-1];
  rx_result_t        expected_results [$];

  task automatic queue_frame_report();
    rx_result_t r;
    r      = '0;
    r.kind = KIND_FRAME;
    r.cmd  = held_cmd;
    r.len  = held_len;
    r.cidx = (held_cmd < COMMAND_COUNT) ? held_cmd[CIDX_W-1:0] : CIDX_W'(COMMAND_COUNT);
    expected_results.push_back(r);
    rx_phase = RX_IDLE;
  endtask

  task automatic take_rx_byte(input logic [BYTE_W-1:0] b);
    if (rx_phase != RX_HEADER && rx_phase != RX_PAYLOAD) begin
      if (b == marker) begin
        rx_phase   = RX_HEADER;
        frame_xor  = b;
        frame_pos  = '0;
        idle_ticks = '0;
      end
    end else if (idle_ticks > timeout) begin
      // late byte goes with the frame
      rx_phase = RX_IDLE;
    end else begin
      idle_ticks = '0;
      if (rx_phase == RX_HEADER) begin
        frame_pos = frame_pos + 1'b1;
        if (frame_pos == 8'd1) begin
          held_cmd  = b;
          frame_xor = frame_xor ^ b;
        end else if (frame_pos == 8'd2) begin
          held_len  = b;
          frame_xor = frame_xor ^ b;
        end else if (frame_xor != b) begin
          rx_phase = RX_IDLE;
        end else if (held_len == '0) begin
          queue_frame_report();
        end else begin
          rx_phase  = RX_PAYLOAD;
          frame_xor = '0;
          frame_pos = '0;
        end
      end else if (frame_pos != held_len) begin
        payload_mem[frame_pos] = b;
        frame_pos = frame_pos + 1'b1;
        frame_xor = frame_xor ^ b;
      end else if (frame_xor != b) begin
        rx_phase = RX_IDLE;
      end else begin
        queue_frame_report();
      end
    end
  endtask

  task automatic absorb_item(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] b,
                             input logic [BYTE_W-1:0] idx);
    rx_result_t r;
    r = '0;
    case (mode)
      MODE_BYTE: take_rx_byte(b);
      MODE_TICK: begin
        if (idle_ticks != {TICK_W{1'b1}}) idle_ticks = idle_ticks + 1'b1;
      end
      MODE_READ: begin
        r.kind  = KIND_READ;
        r.rdata = payload_mem[idx];
        expected_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                             input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result();
    rx_result_t w;
    if (expected_results.size() == 0) begin
      $error("unexpected result item: result_kind %0d, none expected", out_mon.result_kind);
      fail_count++;
    end else begin
      w = expected_results.pop_front();
      if (w.kind == KIND_FRAME) frames_seen++;
      else reads_seen++;
      check_field("result_kind", BYTE_W'(w.kind), BYTE_W'(out_mon.result_kind));
      check_field("command_id", w.cmd, out_mon.command_id);
      check_field("payload_length", w.len, out_mon.payload_length);
      check_field("command_index", BYTE_W'(w.cidx), BYTE_W'(out_mon.command_index));
      check_field("read_byte", w.rdata, out_mon.read_byte);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      marker     = START_MARKER_RST;
      timeout    = TIMEOUT_TICKS_RST;
      rx_phase   = RX_IDLE;
      frame_xor  = '0;
      frame_pos  = '0;
      held_cmd   = '0;
      held_len   = '0;
      idle_ticks = '0;
      expected_results.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_START_MARKER) marker = cfg_data[BYTE_W-1:0];
        else if (cfg_index == CFG_TIMEOUT_TICKS) timeout = cfg_data[TICK_W-1:0];
      end
      if (in_mon.valid && in_mon.ready)
        absorb_item(in_mon.mode, in_mon.rx_byte, in_mon.read_index);
      if (out_mon.valid && out_mon.ready) check_result();
      pending <= expected_results.size();
    end
  end

endmodule

@@ bench/tb_xor_checked_command_frame_receiver.sv @@
// Top of the command frame receiver bench: clock, reset, register writes and
// item stimulus with random sender gaps and receiver stalls; verdict at the end.
// Depends on xcfr_pkg, xcfr_if, the receiver and xcfr_frame_checker.
`timescale 1ns / 100ps

module tb_xor_checked_command_frame_receiver;
  import xcfr_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_GOAL = 780;
  localparam int PHASES      = 6;

  typedef enum int {FR_GOOD, FR_BAD_HEADER, FR_BAD_PAYLOAD, FR_LATE, FR_CUT} frame_fault_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  xcfr_in_if  in_ch ();
  xcfr_out_if out_ch ();

  int fail_count, pending, frames_seen, reads_seen;
  int useful_sent, ticks_sent, items_sent, settings_done;
  int burst_left, quiet, cyc, stall_style, stall_left;
  int errors, base, ph;
  bit store_filled;
  logic [BYTE_W-1:0] cur_marker;
  int                cur_timeout;

  xor_checked_command_frame_receiver DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  xcfr_frame_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .frames_seen (frames_seen),
    .reads_seen  (reads_seen)
  );

  always #6 clk = ~clk;

  // receiver stall pattern, changes style every so often
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left  <= $urandom_range(16, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(0, 1));
      2: out_ch.ready <= (cyc % 5) >= 2;
      default: out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic put_item(input logic [MODE_W-1:0] m, input logic [BYTE_W-1:0] b,
                          input logic [BYTE_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= m;
    in_ch.rx_byte    <= b;
    in_ch.read_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (m == MODE_BYTE || m == MODE_READ) useful_sent++;
    if (m == MODE_TICK) ticks_sent++;
  endtask

  task automatic put_byte(input logic [BYTE_W-1:0] b);
    put_item(MODE_BYTE, b, 8'($urandom));
  endtask

  task automatic put_tick();
    put_item(MODE_TICK, 8'($urandom), 8'($urandom));
  endtask

  // index 255 is never written by any frame
  task automatic put_read(input logic [BYTE_W-1:0] idx);
    put_item(MODE_READ, 8'($urandom), idx);
  endtask

  task automatic quiesce();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [BYTE_W-1:0] marker, input logic [TICK_W-1:0] ticks);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START_MARKER;
    cfg_data  <= CFG_DATA_W'(marker);
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT_TICKS;
    cfg_data  <= ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_marker  = marker;
    cur_timeout = int'(ticks);
    settings_done++;
  endtask

  // no ticks and no reads until the store has been filled
  task automatic spacer(input frame_fault_t f);
    int n;
    if (!store_filled) return;
    if (f == FR_LATE) n = $urandom_range(cur_timeout, cur_timeout + 1);
    else n = $urandom_range(0, (cur_timeout < 4) ? cur_timeout : 4);
    repeat (n) put_tick();
    if ($urandom_range(0, 5) == 0) put_read(8'($urandom_range(0, 254)));
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] len,
                            input frame_fault_t f);
    logic [BYTE_W-1:0] hsum, psum, pb;
    frame_fault_t g;
    int i;
    hsum = cur_marker ^ cmd ^ len;
    psum = '0;
    g = (f == FR_LATE) ? FR_GOOD : f;
    put_byte(cur_marker);
    spacer(f);
    put_byte(cmd);
    if (f == FR_CUT) return;
    spacer(g);
    put_byte(len);
    spacer(g);
    put_byte(f == FR_BAD_HEADER ? hsum ^ (8'd1 << $urandom_range(0, 7)) : hsum);
    if (len != 0) begin
      for (i = 0; i < len; i++) begin
        pb = 8'($urandom);
        psum = psum ^ pb;
        spacer(g);
        put_byte(pb);
      end
      spacer(g);
      put_byte(f == FR_BAD_PAYLOAD ? psum ^ (8'd1 << $urandom_range(0, 7)) : psum);
    end
  endtask

  task automatic random_step();
    int sel;
    frame_fault_t f;
    logic [BYTE_W-1:0] cmd, len, nb;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      cmd = $urandom_range(0, 1) ? 8'($urandom_range(0, 6)) : 8'($urandom);
      len = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(9, 64)) : 8'($urandom_range(0, 8));
      sel = $urandom_range(0, 99);
      if (sel < 74) f = FR_GOOD;
      else if (sel < 82) f = FR_BAD_HEADER;
      else if (sel < 90) f = (len != 0) ? FR_BAD_PAYLOAD : FR_BAD_HEADER;
      else if (sel < 96 && cur_timeout <= 16) begin
        f   = FR_LATE;
        len = 8'($urandom_range(0, 3));
      end else f = FR_CUT;
      send_frame(cmd, len, f);
    end else if (sel < 85) begin
      put_read(8'($urandom_range(0, 254)));
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          nb = 8'($urandom);
          if (nb == cur_marker && $urandom_range(0, 7) != 0) nb = ~nb;
          put_byte(nb);
        end
        1: put_tick();
        default: put_item(MODE_SPARE, 8'($urandom), 8'($urandom));
      endcase
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_START_MARKER;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.mode       = MODE_BYTE;
    in_ch.rx_byte    = '0;
    in_ch.read_index = '0;
    cur_marker       = START_MARKER_RST;
    cur_timeout      = TIMEOUT_TICKS_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    set_config(START_MARKER_RST, TIMEOUT_TICKS_RST);

    // fill store positions 0..254 so that any later read is defined
    send_frame(8'd4, 8'd255, FR_GOOD);
    store_filled = 1'b1;

    send_frame(8'd0, 8'd0, FR_GOOD);
    send_frame(8'd255, 8'd0, FR_GOOD);
    send_frame(8'd5, 8'd2, FR_GOOD);
    put_read(8'd0);
    put_read(8'd254);
    send_frame(8'd1, 8'd0, FR_BAD_HEADER);
    send_frame(8'd2, 8'd1, FR_BAD_PAYLOAD);
    put_item(MODE_SPARE, 8'hFF, 8'hFF);

    // zero timeout: one tick before a byte drops it, and the late byte
    // must not reopen a frame even though it equals the marker
    quiesce();
    set_config(START_MARKER_RST, 16'd0);
    put_byte(START_MARKER_RST);
    put_tick();
    put_byte(START_MARKER_RST);
    put_byte(8'd3);
    put_byte(8'd0);
    put_byte(START_MARKER_RST ^ 8'd3);
    send_frame(8'd3, 8'd0, FR_GOOD);

    base = items_sent;
    for (ph = 0; ph < PHASES; ph++) begin
      quiesce();
      case (ph)
        0: set_config(START_MARKER_RST, TIMEOUT_TICKS_RST);
        1: set_config(8'd0, 16'd0);
        2: set_config(8'd255, 16'd3);
        3: set_config(8'($urandom), 16'($urandom_range(1, 12)));
        4: set_config(8'($urandom), 16'd65534);
        default: set_config(8'($urandom), 16'hFFFF);
      endcase
      while (items_sent < base + RANDOM_GOAL * (ph + 1) / PHASES) random_step();
    end

    quiesce();
    repeat (8) @(posedge clk);
    errors = fail_count;
    if (pending != 0) begin
      $error("%0d expected results never arrived", pending);
      errors++;
    end
    $display("Sent %0d byte and read items plus %0d ticks over %0d register settings,",
             useful_sent, ticks_sent, settings_done);
    $display("checking %0d frame reports and %0d store reads in %0d cycles.",
             frames_seen, reads_seen, cyc);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ xor_checked_command_frame_receiver.f @@
design/xcfr_pkg.sv
design/xcfr_if.sv
design/xcfr_ram.sv
design/xor_checked_command_frame_receiver.sv
bench/xcfr_frame_checker.sv
bench/tb_xor_checked_command_frame_receiver.sv
